@@ design/kdtree_nearest_neighbor_search_unit_macros.svh @@
// Assertion macros used by the checker file kdnn_checker.sv.
// No dependencies.
`ifndef KDTREE_NEAREST_NEIGHBOR_SEARCH_UNIT_MACROS_SVH
`define KDTREE_NEAREST_NEIGHBOR_SEARCH_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define KD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdtree check failed");
// next-cycle implication checked outside reset
`define KD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdtree check failed");
`endif

@@ design/kdnn_pkg.sv @@
// Package for the kd-tree nearest-neighbor search unit: sizes, types, codes.
// No dependencies.
package kdnn_pkg;
    localparam int unsigned NodeCapacityDefault = 16384;
    localparam int unsigned StackDepthDefault   = 64;
    localparam int unsigned IdxW   = 14;
    localparam int unsigned CoordW = 16;
    localparam int unsigned DistW  = 36;
    localparam int unsigned OutDistW = 34;
    localparam int unsigned InDataW  = 96;  // 14+48+28 = 90 padded to 12 bytes

    typedef enum logic {REQ_LOAD = 1'b0, REQ_QUERY = 1'b1} req_kind_t;

    typedef enum logic [1:0] {AXIS_X = 2'd0, AXIS_Y = 2'd1, AXIS_Z = 2'd2}
        axis_t;

    typedef struct packed {
        logic                    kind;
        logic [IdxW-1:0]         index;
        logic signed [CoordW-1:0] x;
        logic signed [CoordW-1:0] y;
        logic signed [CoordW-1:0] z;
        logic [IdxW-1:0]         left;
        logic [IdxW-1:0]         right;
    } req_t;

    typedef struct packed {
        logic [IdxW-1:0]     index;
        logic [OutDistW-1:0] dist_sq;
        logic                ovf;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_POP, ST_RDSTK, ST_RDNODE, ST_SQUARE, ST_SUM,
        ST_UPDATE, ST_PUSHFAR, ST_PUSHNEAR, ST_DONE
    } walk_state_t;
endpackage

@@ design/kdtree_nearest_neighbor_search_unit.sv @@
// Top level of the kd-tree nearest-neighbor search unit; uses kdnn_pkg,
// kdnn_front and kdnn_back. Load: one per cycle through a two-entry queue while no walk
//   runs, no result. Query: after the queue, a walk of start, then per visited node
//   pop, stack read, table read, squares, sum, best update and two pushes, then
//   final pop and done. One walk at a time; done holds while a result waits.
// rst_n clears control state; node table and stack hold garbage until written.
module kdtree_nearest_neighbor_search_unit #(
    parameter int unsigned NODE_CAPACITY = kdnn_pkg::NodeCapacityDefault,
    parameter int unsigned STACK_DEPTH   = kdnn_pkg::StackDepthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: node_index[13:0], coord_x[29:14], coord_y[45:30], coord_z[61:46],
    //        left_child[75:62], right_child[89:76], zero[95:90]
    input  logic [95:0] s_axis_tdata,
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: nearest_index[13:0], nearest_dist_sq[47:14], stack_overflowed[48],
    //        zero[55:49]
    output logic [55:0] m_axis_tdata
);
    import kdnn_pkg::*;

    req_t in_req, q_req;
    res_t res;
    logic q_valid, q_ready;

    assign in_req.kind  = s_axis_tuser;
    assign in_req.index = s_axis_tdata[13:0];
    assign in_req.x     = s_axis_tdata[29:14];
    assign in_req.y     = s_axis_tdata[45:30];
    assign in_req.z     = s_axis_tdata[61:46];
    assign in_req.left  = s_axis_tdata[75:62];
    assign in_req.right = s_axis_tdata[89:76];

    kdnn_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    kdnn_back #(.NODE_CAPACITY(NODE_CAPACITY), .STACK_DEPTH(STACK_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {7'd0, res.ovf, res.dist_sq, res.index};
endmodule

@@ design/kdnn_front.sv @@
// Front part: accepts requests and queues them two deep for the back part.
// Depends on kdnn_pkg.
module kdnn_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  kdnn_pkg::req_t   in_req,
    output logic             q_valid,
    input  logic             q_ready,
    output kdnn_pkg::req_t   q_req
);
    import kdnn_pkg::*;

    req_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_req    = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_req;
    end
endmodule

@@ design/kdnn_back.sv @@
// Back part: node table, search stack and tree walk sequencer.
// Depends on kdnn_pkg.
module kdnn_back #(
    parameter int unsigned NODE_CAPACITY = kdnn_pkg::NodeCapacityDefault,
    parameter int unsigned STACK_DEPTH   = kdnn_pkg::StackDepthDefault
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  kdnn_pkg::req_t  q_req,
    output logic            res_valid,
    input  logic            res_ready,
    output kdnn_pkg::res_t  res
);
    import kdnn_pkg::*;

    localparam int unsigned NodeAw  = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
    localparam int unsigned StackAw = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned LevelW  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned VisitW  = $clog2(NODE_CAPACITY + 1);
    // one bit above the index so the capacity itself is representable
    localparam int unsigned WideIdx = ((NodeAw > IdxW) ? NodeAw : IdxW) + 1;

    typedef struct packed {
        logic [1:0]      axis;
        logic [IdxW-1:0] index;
    } stk_entry_t;

    logic [3*CoordW-1:0]   point_mem [NODE_CAPACITY];
    logic [2*IdxW-1:0]     link_mem  [NODE_CAPACITY];
    stk_entry_t            stack_mem [STACK_DEPTH];

    walk_state_t state_reg, state_next;

    logic signed [CoordW-1:0] tx_reg, ty_reg, tz_reg;
    logic [LevelW-1:0]     level_reg;
    logic [VisitW-1:0]     visits_reg;
    logic [DistW-1:0]      best_reg;
    logic [IdxW-1:0]       best_idx_reg;
    logic                  ovf_reg;
    stk_entry_t            stk_rd_reg;
    logic [3*CoordW-1:0]   pt_rd_reg;
    logic [2*IdxW-1:0]     ln_rd_reg;
    logic [1:0]            axis_reg;
    logic [IdxW-1:0]       cur_idx_reg;
    logic [2*CoordW-1:0]   sq_reg [3];
    logic [2*CoordW-1:0]   plane_reg;
    logic [DistW-1:0]      dist_reg;
    logic                  t_less_reg;
    res_t                  res_reg;
    logic                  res_valid_reg;

    logic signed [CoordW:0] diff [3];
    logic signed [CoordW:0] pdiff;
    logic signed [CoordW-1:0] pc [3];
    logic signed [CoordW-1:0] tc [3];
    logic [IdxW-1:0]  left_c, right_c, near_c, far_c;
    logic             near_ok, far_ok, push_far;
    logic [DistW-1:0] best_now;
    logic             is_load, load_ok;

    function automatic logic child_ok(input logic [IdxW-1:0] c);
        logic [WideIdx-1:0] cw;
        cw = WideIdx'(c);
        return (c != '0) && (cw < WideIdx'(NODE_CAPACITY));
    endfunction

    assign is_load = (q_req.kind == REQ_LOAD);
    assign load_ok = child_ok(q_req.index) || (q_req.index == '0);
    // a waiting result is held in res_reg, so the next walk may start
    assign q_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    assign pc[0] = pt_rd_reg[CoordW-1:0];
    assign pc[1] = pt_rd_reg[2*CoordW-1:CoordW];
    assign pc[2] = pt_rd_reg[3*CoordW-1:2*CoordW];
    assign tc[0] = tx_reg;
    assign tc[1] = ty_reg;
    assign tc[2] = tz_reg;
    assign left_c  = ln_rd_reg[IdxW-1:0];
    assign right_c = ln_rd_reg[2*IdxW-1:IdxW];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            diff[k] = {pc[k][CoordW-1], pc[k]} - {tc[k][CoordW-1], tc[k]};
        pdiff = {tc[axis_reg][CoordW-1], tc[axis_reg]}
              - {pc[axis_reg][CoordW-1], pc[axis_reg]};
    end

    // best after this node's update
    assign best_now = (dist_reg < best_reg) ? dist_reg : best_reg;
    assign near_c   = t_less_reg ? left_c : right_c;
    assign far_c    = t_less_reg ? right_c : left_c;
    assign near_ok  = child_ok(near_c);
    assign far_ok   = child_ok(far_c);
    assign push_far = (DistW'(plane_reg) < best_reg) && far_ok;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid && q_ready && !is_load)
                    state_next = ST_START;
            ST_START:    state_next = ST_POP;
            ST_POP:
                if (level_reg == '0 || visits_reg == VisitW'(NODE_CAPACITY))
                    state_next = ST_DONE;
                else
                    state_next = ST_RDSTK;
            ST_RDSTK:    state_next = ST_RDNODE;
            ST_RDNODE:
                if (child_ok(stk_rd_reg.index) || stk_rd_reg.index == '0)
                    state_next = ST_SQUARE;
                else
                    state_next = ST_POP;
            ST_SQUARE:   state_next = ST_SUM;
            ST_SUM:      state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_PUSHFAR;
            ST_PUSHFAR:  state_next = ST_PUSHNEAR;
            ST_PUSHNEAR: state_next = ST_POP;
            ST_DONE:
                if (!res_valid_reg)
                    state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            level_reg     <= '0;
            visits_reg    <= '0;
            best_reg      <= '1;
            best_idx_reg  <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_START:
                begin
                    // root goes on the stack
                    level_reg    <= LevelW'(1);
                    visits_reg   <= '0;
                    best_reg     <= '1;
                    best_idx_reg <= '0;
                    ovf_reg      <= 1'b0;
                end
                ST_POP:
                    if (!(level_reg == '0 || visits_reg == VisitW'(NODE_CAPACITY)))
                    begin
                        level_reg  <= level_reg - LevelW'(1);
                        visits_reg <= visits_reg + VisitW'(1);
                    end
                ST_UPDATE:
                    if (dist_reg < best_reg)
                    begin
                        best_reg     <= dist_reg;
                        best_idx_reg <= cur_idx_reg;
                    end
                ST_PUSHFAR:
                    if (push_far)
                    begin
                        if (level_reg < LevelW'(STACK_DEPTH))
                            level_reg <= level_reg + LevelW'(1);
                        else
                            ovf_reg <= 1'b1;
                    end
                ST_PUSHNEAR:
                    if (near_ok)
                    begin
                        if (level_reg < LevelW'(STACK_DEPTH))
                            level_reg <= level_reg + LevelW'(1);
                        else
                            ovf_reg <= 1'b1;
                    end
                ST_DONE:
                    if (!res_valid_reg)
                        res_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid && q_ready)
        begin
            if (is_load && load_ok)
            begin
                point_mem[q_req.index[NodeAw-1:0]] <= {q_req.z, q_req.y, q_req.x};
                link_mem[q_req.index[NodeAw-1:0]]  <= {q_req.right, q_req.left};
            end
            tx_reg <= q_req.x;
            ty_reg <= q_req.y;
            tz_reg <= q_req.z;
        end
        if (state_reg == ST_START)
            stack_mem[0] <= '{axis: AXIS_X, index: '0};
        if (state_reg == ST_RDSTK)
            stk_rd_reg <= stack_mem[StackAw'(level_reg)];
        if (state_reg == ST_RDNODE)
        begin
            pt_rd_reg   <= point_mem[stk_rd_reg.index[NodeAw-1:0]];
            ln_rd_reg   <= link_mem[stk_rd_reg.index[NodeAw-1:0]];
            axis_reg    <= (stk_rd_reg.axis > 2'd2) ? AXIS_X : stk_rd_reg.axis;
            cur_idx_reg <= stk_rd_reg.index;
        end
        if (state_reg == ST_SQUARE)
        begin
            for (int k = 0; k < 3; k++)
                sq_reg[k] <= (2*CoordW)'(diff[k] * diff[k]);
            plane_reg  <= (2*CoordW)'(pdiff * pdiff);
            t_less_reg <= (tc[axis_reg] < pc[axis_reg]);
        end
        if (state_reg == ST_SUM)
            dist_reg <= DistW'(sq_reg[0]) + DistW'(sq_reg[1]) + DistW'(sq_reg[2]);
        if (state_reg == ST_PUSHFAR && push_far && level_reg < LevelW'(STACK_DEPTH))
            stack_mem[StackAw'(level_reg)] <=
                '{axis: (axis_reg == AXIS_Z) ? AXIS_X : axis_reg + 2'd1, index: far_c};
        if (state_reg == ST_PUSHNEAR && near_ok && level_reg < LevelW'(STACK_DEPTH))
            stack_mem[StackAw'(level_reg)] <=
                '{axis: (axis_reg == AXIS_Z) ? AXIS_X : axis_reg + 2'd1, index: near_c};
        if (state_reg == ST_DONE && !res_valid_reg)
            res_reg <= '{index: best_idx_reg, dist_sq: best_now[OutDistW-1:0],
                         ovf: ovf_reg};
    end
endmodule

@@ design/kdnn_checker.sv @@
// Port-level checker for the search unit, bound to the top level.
// Depends on kdtree_nearest_neighbor_search_unit_macros.svh.
`include "kdtree_nearest_neighbor_search_unit_macros.svh"
module kdnn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    `KD_ASSERT_NEXT(result_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `KD_ASSERT_IMPL(pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[55:49] == 7'd0)
    `KD_ASSERT_NEXT(no_back_to_back_result, clk, rst_n, m_axis_tvalid && m_axis_tready,
        !m_axis_tvalid)
endmodule

bind kdtree_nearest_neighbor_search_unit kdnn_checker u_kdnn_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

@@ bench/testbench.sv @@
// Testbench for the kd-tree nearest-neighbor search unit: loads random trees,
// sends queries, and checks each answer against an exact tree walk.
// Depends on kdnn_pkg and kdtree_nearest_neighbor_search_unit.
`timescale 1ns / 100ps

module testbench;
    import kdnn_pkg::*;

    localparam int unsigned NODES      = 16384;
    localparam int unsigned DEPTH      = 64;
    localparam int unsigned ITEM_GOAL  = 1450;
    localparam int unsigned STALL_MAX  = 600000;
    localparam longint unsigned DIST_START = 64'hF_FFFF_FFFF;

    class nn_scoreboard;
        logic [47:0] points [NODES];
        logic [27:0] links [NODES];
        logic [15:0] walk_stack [DEPTH];
        int unsigned depth_used;
        logic [48:0] answers [$];
        int unsigned mismatches;

        function void push_node(int unsigned idx, int unsigned axis, ref bit ovf);
            if (depth_used < DEPTH)
            begin
                walk_stack[depth_used] = {axis[1:0], idx[13:0]};
                depth_used++;
            end
            else
                ovf = 1'b1;
        endfunction

        // Note an accepted request: store a node or predict a query answer.
        function void note_request(req_t r);
            longint t [3];
            longint p [3];
            longint d;
            longint unsigned node_dist, plane, best;
            int unsigned best_idx, visits, idx, axis, nxt, lf, rt, near_c, far_c;
            bit ovf;
            if (r.kind == REQ_LOAD)
            begin
                points[r.index] = {r.z, r.y, r.x};
                links[r.index]  = {r.right, r.left};
                return;
            end
            t[0] = $signed(r.x);
            t[1] = $signed(r.y);
            t[2] = $signed(r.z);
            depth_used = 0;
            best = DIST_START;
            best_idx = 0;
            visits = 0;
            ovf = 1'b0;
            push_node(0, AXIS_X, ovf);
            while (depth_used > 0 && visits < NODES)
            begin
                visits++;
                depth_used--;
                idx  = walk_stack[depth_used][13:0];
                axis = walk_stack[depth_used][15:14];
                if (axis > AXIS_Z)
                    axis = AXIS_X;
                p[0] = $signed(points[idx][15:0]);
                p[1] = $signed(points[idx][31:16]);
                p[2] = $signed(points[idx][47:32]);
                node_dist = 0;
                for (int k = 0; k < 3; k++)
                begin
                    d = p[k] - t[k];
                    node_dist += d * d;
                end
                if (node_dist < best)
                begin
                    best = node_dist;
                    best_idx = idx;
                end
                nxt = (axis == AXIS_Z) ? AXIS_X : axis + 1;
                lf = links[idx][13:0];
                rt = links[idx][27:14];
                if (t[axis] < p[axis])
                begin
                    near_c = lf;
                    far_c = rt;
                end
                else
                begin
                    near_c = rt;
                    far_c = lf;
                end
                d = t[axis] - p[axis];
                plane = d * d;
                if (plane < best && far_c != 0)
                    push_node(far_c, nxt, ovf);
                if (near_c != 0)
                    push_node(near_c, nxt, ovf);
            end
            answers.push_back({ovf, best[33:0], best_idx[13:0]});
        endfunction

        function void check_result(logic [55:0] data);
            logic [48:0] want;
            if (answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected answer index=%0d dist=%0d ovf=%0b", $realtime,
                             data[13:0], data[47:14], data[48]);
                return;
            end
            want = answers.pop_front();
            if (data[48:0] !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: answer mismatch: expected index=%0d dist=%0d ovf=%0b,",
                              " got index=%0d dist=%0d ovf=%0b"},
                             $realtime, want[13:0], want[47:14], want[48],
                             data[13:0], data[47:14], data[48]);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    nn_scoreboard sb;
    bit steady;
    int unsigned sent;
    int unsigned stall_cycles;
    int unsigned tree_nodes [$];
    bit in_tree [int unsigned];

    kdtree_nearest_neighbor_search_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Take answers, with random back-pressure unless in the steady stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            m_axis_tready <= steady ? 1'b1 : ($urandom_range(99) >= 33);
        end
    end

    // Abort when nothing moves for too long while work is outstanding.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (s_axis_tvalid || sb.answers.size() > 0)
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_request(req_t r);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.kind;
        s_axis_tdata  <= {6'b0, r.right, r.left, r.z, r.y, r.x, r.index};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(r);
        sent++;
        if (!steady && $urandom_range(99) < 33)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic load_node(int unsigned idx, int x, int y, int z,
                             int unsigned lf, int unsigned rt);
        req_t r;
        r.kind  = REQ_LOAD;
        r.index = IdxW'(idx);
        r.x = CoordW'(x);
        r.y = CoordW'(y);
        r.z = CoordW'(z);
        r.left  = IdxW'(lf);
        r.right = IdxW'(rt);
        send_request(r);
    endtask

    task automatic query_point(int x, int y, int z);
        req_t r;
        r.kind  = REQ_QUERY;
        r.index = IdxW'($urandom_range(NODES - 1));
        r.x = CoordW'(x);
        r.y = CoordW'(y);
        r.z = CoordW'(z);
        r.left  = IdxW'($urandom_range(NODES - 1));
        r.right = IdxW'($urandom_range(NODES - 1));
        send_request(r);
    endtask

    task automatic drain_answers();
        s_axis_tvalid <= 1'b0;
        while (sb.answers.size() > 0)
            @(posedge clk);
    endtask

    function automatic int pick_coord(bit narrow);
        return narrow ? $urandom_range(16) - 8 : $urandom_range(65535) - 32768;
    endfunction

    // Load a random tree rooted at 0 whose children are all loaded nodes.
    task automatic load_random_tree(int unsigned count, bit narrow);
        int unsigned lf [$];
        int unsigned rt [$];
        int unsigned idx, parent;
        tree_nodes.delete();
        in_tree.delete();
        tree_nodes.push_back(0);
        in_tree[0] = 1'b1;
        while (tree_nodes.size() < count)
        begin
            idx = $urandom_range(1, NODES - 1);
            if (!in_tree.exists(idx))
            begin
                tree_nodes.push_back(idx);
                in_tree[idx] = 1'b1;
            end
        end
        for (int k = 0; k < count; k++)
        begin
            lf.push_back(0);
            rt.push_back(0);
        end
        for (int k = 1; k < count; k++)
        begin
            do
                parent = $urandom_range(k - 1);
            while (lf[parent] != 0 && rt[parent] != 0);
            if (lf[parent] == 0 && (rt[parent] != 0 || $urandom_range(1)))
                lf[parent] = tree_nodes[k];
            else
                rt[parent] = tree_nodes[k];
        end
        for (int k = count - 1; k >= 0; k--)
            load_node(tree_nodes[k], pick_coord(narrow), pick_coord(narrow),
                      pick_coord(narrow), lf[k], rt[k]);
    endtask

    initial
    begin
        int unsigned phase, count, extra;
        bit narrow;
        sb = new();
        steady = 1'b0;
        sent = 0;
        stall_cycles = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single root at one corner, queried from the opposite corner and on it.
        load_node(0, -32768, -32768, -32768, 0, 0);
        query_point(32767, 32767, 32767);
        query_point(-32768, -32768, -32768);
        load_node(0, 32767, 32767, 32767, 0, 0);
        query_point(-32768, -32768, -32768);

        // A node linked to itself on both sides: the stack fills and the walk
        // runs until the visit bound.
        load_node(16383, 7, -7, 3, 0, 0);
        load_node(1, 0, 0, 0, 1, 1);
        load_node(0, 0, 0, 0, 1, 16383);
        query_point(0, 0, 1);
        drain_answers();

        // Small tree with equal points to exercise ties.
        load_node(2, 1, 1, 1, 0, 0);
        load_node(3, 1, 1, 1, 0, 0);
        load_node(0, 1, 1, 1, 2, 3);
        query_point(1, 1, 1);
        query_point(0, 2, 1);

        phase = 0;
        while (sent < ITEM_GOAL)
        begin
            steady = (phase >= 8 && phase < 12);
            narrow = ($urandom_range(3) == 0);
            count = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 20);
            load_random_tree(count, narrow);
            extra = $urandom_range(3, 15);
            for (int k = 0; k < extra; k++)
            begin
                if ($urandom_range(5) == 0)
                begin
                    int unsigned idx;
                    do
                        idx = $urandom_range(NODES - 1);
                    while (in_tree.exists(idx));
                    load_node(idx, pick_coord(0), pick_coord(0), pick_coord(0),
                              $urandom_range(NODES - 1), $urandom_range(NODES - 1));
                end
                else
                    query_point(pick_coord(narrow), pick_coord(narrow), pick_coord(narrow));
            end
            if (phase % 5 == 4)
                drain_answers();
            phase++;
        end
        steady = 1'b0;
        drain_answers();
        repeat (100) @(posedge clk);
        if (sb.mismatches == 0 && sb.answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
